@@ sv/apsp_pkg.sv @@
package apsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 64;

  localparam int VIDX_W = $clog2(MAX_VERTICES);   // vertex index
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1); // vertex count
  localparam int EIDX_W = $clog2(MAX_EDGES);      // edge table address
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);  // edge count
  localparam int COST_W = 16;                     // edge cost
  localparam int OUT_W  = 24;                     // reported path cost
  localparam int POT_W  = 28;                     // potentials and working distances
  localparam int DM_W   = OUT_W + 1;              // reach flag + cost
  localparam int EDGE_W = 2 * VIDX_W + COST_W;    // tail, head, cost
  localparam int DM_AW  = 2 * VIDX_W;

  localparam logic signed [POT_W+1:0] SAT_MAX = 30'sd8388607;
  localparam logic signed [POT_W+1:0] SAT_MIN = -30'sd8388608;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

endpackage

@@ sv/apsp_ram.sv @@
module apsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/all_pairs_shortest_paths.sv @@
// All-pairs shortest paths over a small directed graph (Johnson's scheme).
//
// Input channel (in_valid / in_stall): one transaction per request. req_type
// selects clear graph, add edge (edge_from -> edge_to, cost edge_weight) or
// query distances from source edge_from. Clear and add are accepted back to
// back; neither gives a result.
// Output channel (out_valid / out_stall): a query returns one transaction
// per vertex (vertex_count clamped to 1..16), destinations in ascending order, last set on the final one.
// A query after any change first recomputes all pairs: Bellman-Ford over up
// to n+1 passes of the edge list, then per source Dijkstra rounds of a vertex
// scan plus an edge pass, and a row writeback; all paced by one-port memory
// accesses. A query with current results skips the recompute. Results go out
// one at a time; the next is not read until the current one is taken.
// While a query is in progress in_stall is high. A stalled result holds its
// output register until taken.
// Reset: empty edge table, vertex_count 16, flags cleared, results stale.
// The edge, potential, distance and matrix memories need no clearing pass.
// vertex_count is written via cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this.
module all_pairs_shortest_paths (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [apsp_pkg::VCNT_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [apsp_pkg::VIDX_W-1:0]       edge_from,
  input  logic [apsp_pkg::VIDX_W-1:0]       edge_to,
  input  logic signed [apsp_pkg::COST_W-1:0] edge_weight,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [apsp_pkg::VIDX_W-1:0]       dest_vertex,
  output logic signed [apsp_pkg::OUT_W-1:0] path_cost,
  output logic                              reachable,
  output logic                              negative_cycle,
  output logic                              edges_dropped,
  output logic                              last
);
  import apsp_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_BF_INIT = 20'h00002,
    S_BF_ERD  = 20'h00004,
    S_BF_ECHK = 20'h00008,
    S_BF_PA   = 20'h00010,
    S_BF_UPD  = 20'h00020,
    S_DJ_INIT = 20'h00040,
    S_DJ_PSRC = 20'h00080,
    S_DJ_SRD  = 20'h00100,
    S_DJ_SCMP = 20'h00200,
    S_DJ_PB   = 20'h00400,
    S_DJ_PBL  = 20'h00800,
    S_DJ_ERD  = 20'h01000,
    S_DJ_ECHK = 20'h02000,
    S_DJ_UPD  = 20'h04000,
    S_DJ_WRD  = 20'h08000,
    S_DJ_WWR  = 20'h10000,
    S_Q_RD    = 20'h20000,
    S_Q_LD    = 20'h40000,
    S_Q_WAIT  = 20'h80000
  } state_t;

  state_t state;

  // control state
  logic [VCNT_W-1:0] vertex_count;
  logic [ECNT_W-1:0] edge_total;
  logic              results_current;
  logic              cycle_found;
  logic              overflow_seen;
  logic [ECNT_W-1:0] e_idx;
  logic [VCNT_W-1:0] pass;
  logic              changed;
  logic [VIDX_W-1:0] v_idx;
  logic [VIDX_W-1:0] u_idx;
  logic [VIDX_W-1:0] q_src;
  logic [VIDX_W-1:0] best;
  logic              found;
  logic [MAX_VERTICES-1:0] seen;
  logic [MAX_VERTICES-1:0] done;

  // datapath registers
  logic [VIDX_W-1:0]        e_head;
  logic signed [COST_W-1:0] e_cost;
  logic signed [POT_W-1:0]  pot_a;
  logic signed [POT_W-1:0]  pot_src;
  logic signed [POT_W-1:0]  pot_best;
  logic signed [POT_W-1:0]  best_dist;

  // memory ports
  logic                    e_we;
  logic [EDGE_W-1:0]       e_wdata, e_rdata;
  logic                    p_we;
  logic [VIDX_W-1:0]       p_waddr, p_raddr;
  logic signed [POT_W-1:0] p_wdata, p_rdata;
  logic                    d_we;
  logic [VIDX_W-1:0]       d_waddr, d_raddr;
  logic signed [POT_W-1:0] d_wdata, d_rdata;
  logic                    m_we;
  logic [DM_W-1:0]         m_wdata, m_rdata;

  logic [VCNT_W-1:0] n;
  logic [VCNT_W-1:0] n_m1;
  logic              v_last, u_last;
  logic [VIDX_W-1:0]        rd_tail, rd_head;
  logic signed [COST_W-1:0] rd_cost;
  logic              rd_usable;
  logic              in_acc;
  logic              take;
  logic signed [POT_W:0]   bf_c;
  logic signed [POT_W+1:0] dj_c_w;
  logic signed [POT_W-1:0] dj_c;
  logic signed [POT_W+1:0] real_w;
  logic signed [OUT_W-1:0] real_sat;

  // 0 acts as 1, anything above the maximum as the maximum
  always_comb begin
    if (vertex_count == '0) begin
      n = VCNT_W'(1);
    end else if (vertex_count > VCNT_W'(MAX_VERTICES)) begin
      n = VCNT_W'(MAX_VERTICES);
    end else begin
      n = vertex_count;
    end
  end

  assign n_m1   = n - VCNT_W'(1);
  assign v_last = ({1'b0, v_idx} == n_m1);
  assign u_last = ({1'b0, u_idx} == n_m1);

  assign rd_tail   = e_rdata[EDGE_W-1 -: VIDX_W];
  assign rd_head   = e_rdata[COST_W +: VIDX_W];
  assign rd_cost   = e_rdata[COST_W-1:0];
  assign rd_usable = ({1'b0, rd_tail} < n) && ({1'b0, rd_head} < n);

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // relaxation arithmetic
  assign bf_c = {pot_a[POT_W-1], pot_a} +
                {{(POT_W+1-COST_W){e_cost[COST_W-1]}}, e_cost};
  assign dj_c_w = {{2{best_dist[POT_W-1]}}, best_dist} +
                  {{(POT_W+2-COST_W){e_cost[COST_W-1]}}, e_cost} +
                  {{2{pot_best[POT_W-1]}}, pot_best} -
                  {{2{p_rdata[POT_W-1]}}, p_rdata};
  assign dj_c = dj_c_w[POT_W-1:0];
  assign take = seen[v_idx] && !done[v_idx] && (!found || (d_rdata < best_dist));

  // real cost = reweighted distance + h(v) - h(src), saturated to 24 bits
  assign real_w = {{2{d_rdata[POT_W-1]}}, d_rdata} +
                  {{2{p_rdata[POT_W-1]}}, p_rdata} -
                  {{2{pot_src[POT_W-1]}}, pot_src};
  always_comb begin
    if (real_w > SAT_MAX) begin
      real_sat = SAT_MAX[OUT_W-1:0];
    end else if (real_w < SAT_MIN) begin
      real_sat = SAT_MIN[OUT_W-1:0];
    end else begin
      real_sat = real_w[OUT_W-1:0];
    end
  end

  // memory port steering
  assign e_we    = in_acc && (req_type == REQ_ADD) && (edge_total < ECNT_W'(MAX_EDGES));
  assign e_wdata = {edge_from, edge_to, edge_weight};

  always_comb begin
    p_we    = 1'b0;
    p_waddr = v_idx;
    p_wdata = '0;
    p_raddr = v_idx;
    d_we    = 1'b0;
    d_waddr = u_idx;
    d_wdata = '0;
    d_raddr = v_idx;
    m_we    = 1'b0;
    m_wdata = '0;
    unique case (state)
      S_BF_INIT: begin
        p_we = 1'b1;
      end
      S_BF_ECHK: begin
        p_raddr = rd_tail;
      end
      S_BF_PA: begin
        p_raddr = e_head;
      end
      S_BF_UPD: begin
        p_waddr = e_head;
        p_wdata = bf_c[POT_W-1:0];
        p_we    = (bf_c < $signed({p_rdata[POT_W-1], p_rdata}));
      end
      S_DJ_INIT: begin
        p_raddr = u_idx;
        d_we    = 1'b1;
      end
      S_DJ_PB: begin
        p_raddr = best;
      end
      S_DJ_ECHK: begin
        p_raddr = rd_head;
        d_raddr = rd_head;
      end
      S_DJ_UPD: begin
        d_waddr = e_head;
        d_wdata = dj_c;
        d_we    = !seen[e_head] || (dj_c < d_rdata);
      end
      S_DJ_WWR: begin
        m_we    = 1'b1;
        m_wdata = seen[v_idx] ? {1'b1, real_sat} : '0;
      end
      S_IDLE, S_BF_ERD, S_DJ_PSRC, S_DJ_SRD, S_DJ_SCMP, S_DJ_PBL,
      S_DJ_ERD, S_DJ_WRD, S_Q_RD, S_Q_LD, S_Q_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  apsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (edge_total[EIDX_W-1:0]),
    .wdata (e_wdata),
    .raddr (e_idx[EIDX_W-1:0]),
    .rdata (e_rdata)
  );

  apsp_ram #(.WIDTH(POT_W), .DEPTH(MAX_VERTICES)) u_pot_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  apsp_ram #(.WIDTH(POT_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  apsp_ram #(.WIDTH(DM_W), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_matrix_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr ({u_idx, v_idx}),
    .wdata (m_wdata),
    .raddr ({q_src, v_idx}),
    .rdata (m_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      vertex_count    <= VCNT_W'(MAX_VERTICES);
      edge_total      <= '0;
      results_current <= 1'b0;
      cycle_found     <= 1'b0;
      overflow_seen   <= 1'b0;
      out_valid       <= 1'b0;
      e_idx           <= '0;
      pass            <= '0;
      changed         <= 1'b0;
      v_idx           <= '0;
      u_idx           <= '0;
      q_src           <= '0;
      best            <= '0;
      found           <= 1'b0;
      seen            <= '0;
      done            <= '0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count    <= cfg_wr_data;
        results_current <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (req_type)
              REQ_CLEAR: begin
                edge_total      <= '0;
                overflow_seen   <= 1'b0;
                cycle_found     <= 1'b0;
                results_current <= 1'b0;
              end
              REQ_ADD: begin
                if (e_we) begin
                  edge_total <= edge_total + ECNT_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
                results_current <= 1'b0;
              end
              REQ_QUERY: begin
                q_src <= edge_from;
                v_idx <= '0;
                state <= results_current ? S_Q_RD : S_BF_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_BF_INIT: begin
          if (v_last) begin
            e_idx   <= '0;
            pass    <= '0;
            changed <= 1'b0;
            state   <= S_BF_ERD;
          end else begin
            v_idx <= v_idx + VIDX_W'(1);
          end
        end
        S_BF_ERD: begin
          if (e_idx == edge_total) begin
            if (!changed) begin
              cycle_found <= 1'b0;
              u_idx       <= '0;
              state       <= S_DJ_INIT;
            end else if (pass == n) begin
              // still relaxing after n+1 passes
              cycle_found     <= 1'b1;
              results_current <= 1'b1;
              v_idx           <= '0;
              state           <= S_Q_RD;
            end else begin
              pass    <= pass + VCNT_W'(1);
              e_idx   <= '0;
              changed <= 1'b0;
            end
          end else begin
            state <= S_BF_ECHK;
          end
        end
        S_BF_ECHK: begin
          e_head <= rd_head;
          e_cost <= rd_cost;
          if (rd_usable) begin
            state <= S_BF_PA;
          end else begin
            e_idx <= e_idx + ECNT_W'(1);
            state <= S_BF_ERD;
          end
        end
        S_BF_PA: begin
          pot_a <= p_rdata;
          state <= S_BF_UPD;
        end
        S_BF_UPD: begin
          if (p_we) begin
            changed <= 1'b1;
          end
          e_idx <= e_idx + ECNT_W'(1);
          state <= S_BF_ERD;
        end
        S_DJ_INIT: begin
          seen  <= MAX_VERTICES'(1) << u_idx;
          done  <= '0;
          state <= S_DJ_PSRC;
        end
        S_DJ_PSRC: begin
          pot_src <= p_rdata;
          v_idx   <= '0;
          found   <= 1'b0;
          state   <= S_DJ_SRD;
        end
        S_DJ_SRD: begin
          state <= S_DJ_SCMP;
        end
        S_DJ_SCMP: begin
          // nearest open vertex, first index wins on a tie
          if (take) begin
            best      <= v_idx;
            best_dist <= d_rdata;
            found     <= 1'b1;
          end
          if (v_last) begin
            v_idx <= '0;
            state <= (found || take) ? S_DJ_PB : S_DJ_WRD;
          end else begin
            v_idx <= v_idx + VIDX_W'(1);
            state <= S_DJ_SRD;
          end
        end
        S_DJ_PB: begin
          done[best] <= 1'b1;
          state      <= S_DJ_PBL;
        end
        S_DJ_PBL: begin
          pot_best <= p_rdata;
          e_idx    <= '0;
          state    <= S_DJ_ERD;
        end
        S_DJ_ERD: begin
          if (e_idx == edge_total) begin
            v_idx <= '0;
            found <= 1'b0;
            state <= S_DJ_SRD;
          end else begin
            state <= S_DJ_ECHK;
          end
        end
        S_DJ_ECHK: begin
          e_head <= rd_head;
          e_cost <= rd_cost;
          if (rd_usable && (rd_tail == best)) begin
            state <= S_DJ_UPD;
          end else begin
            e_idx <= e_idx + ECNT_W'(1);
            state <= S_DJ_ERD;
          end
        end
        S_DJ_UPD: begin
          if (d_we) begin
            seen[e_head] <= 1'b1;
          end
          e_idx <= e_idx + ECNT_W'(1);
          state <= S_DJ_ERD;
        end
        S_DJ_WRD: begin
          state <= S_DJ_WWR;
        end
        S_DJ_WWR: begin
          if (v_last) begin
            v_idx <= '0;
            if (u_last) begin
              results_current <= 1'b1;
              state           <= S_Q_RD;
            end else begin
              u_idx <= u_idx + VIDX_W'(1);
              state <= S_DJ_INIT;
            end
          end else begin
            v_idx <= v_idx + VIDX_W'(1);
            state <= S_DJ_WRD;
          end
        end
        S_Q_RD: begin
          state <= S_Q_LD;
        end
        S_Q_LD: begin
          out_valid <= 1'b1;
          state     <= S_Q_WAIT;
        end
        S_Q_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (v_last) begin
              state <= S_IDLE;
            end else begin
              v_idx <= v_idx + VIDX_W'(1);
              state <= S_Q_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded once per destination
  always_ff @(posedge clk) begin
    if (state == S_Q_LD) begin
      dest_vertex    <= v_idx;
      negative_cycle <= cycle_found;
      edges_dropped  <= overflow_seen;
      last           <= v_last;
      if (({1'b0, q_src} < n) && !cycle_found && m_rdata[DM_W-1]) begin
        reachable <= 1'b1;
        path_cost <= m_rdata[OUT_W-1:0];
      end else begin
        reachable <= 1'b0;
        path_cost <= '0;
      end
    end
  end

endmodule
